>>> hw/rtl/crank_pkg.sv
package crank_pkg;

    localparam int DATA_W           = 32;
    localparam int CFG_W            = 6;
    localparam int CFG_IDX_W        = 2;
    localparam int STATUS_W         = 2;
    localparam int POS_W            = $clog2(DATA_W);
    localparam int MAX_ORBITALS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAIRS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ORBITALS = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] NUM_PAIRS_RST    = CFG_W'(1);
    localparam logic [CFG_W-1:0] NUM_ORBITALS_RST = CFG_W'(2);

    localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_COUNT = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_RANGE = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_SIZE  = STATUS_W'(3);

    typedef struct packed {
        logic [DATA_W-1:0]   rank;
        logic [STATUS_W-1:0] status;
    } t_scan_res;

endpackage

>>> hw/rtl/crank_table.sv
module crank_table #(
    parameter int  MAX_ORBITALS = crank_pkg::MAX_ORBITALS_DEF,
    localparam int WGT_AW       = $clog2(MAX_ORBITALS * MAX_ORBITALS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [crank_pkg::CFG_W-1:0]  i_n,
    input  logic [crank_pkg::CFG_W-1:0]  i_l,
    output logic                         o_done,
    input  logic                         i_rd_en,
    input  logic [WGT_AW-1:0]            i_rd_addr,
    output logic [crank_pkg::DATA_W-1:0] o_rd_data
);
    import crank_pkg::*;

    localparam int PATH_DEPTH = (MAX_ORBITALS + 1) * MAX_ORBITALS;
    localparam int WGT_DEPTH  = MAX_ORBITALS * MAX_ORBITALS;
    localparam int PATH_AW    = $clog2(PATH_DEPTH);
    localparam int EW         = $clog2(MAX_ORBITALS + 1);
    localparam int OW         = $clog2(MAX_ORBITALS);

    typedef enum logic [4:0] {
        T_IDLE    = 5'b00001,
        T_PATH_RD = 5'b00010,
        T_PATH_WR = 5'b00100,
        T_WGT_RD  = 5'b01000,
        T_WGT_WR  = 5'b10000
    } t_tstate;

    logic [DATA_W-1:0] path_mem [PATH_DEPTH];
    logic [DATA_W-1:0] wgt_mem  [WGT_DEPTH];

    t_tstate           r_state, n_state;
    logic [CFG_W-1:0]  r_e, n_e;
    logic [CFG_W-1:0]  r_o, n_o;
    logic [DATA_W-1:0] r_right, n_right;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_path_rd;
    logic [DATA_W-1:0] r_wgt_rd;

    logic [CFG_W-1:0]   last_col;
    logic [CFG_W-1:0]   rd_row;
    logic               path_rd_en;
    logic               path_we;
    logic               wgt_we;
    logic [DATA_W-1:0]  path_val;
    logic [DATA_W-1:0]  wgt_val;
    logic [PATH_AW-1:0] path_rd_addr;
    logic [PATH_AW-1:0] path_wr_addr;
    logic [WGT_AW-1:0]  wgt_wr_addr;

    assign last_col   = i_l - i_n;
    assign path_rd_en = (r_state == T_PATH_RD) || (r_state == T_WGT_RD);
    assign rd_row     = ((r_state == T_PATH_RD) && (r_e == i_n)) ? r_e : r_e + CFG_W'(1);

    assign path_rd_addr = PATH_AW'(rd_row[EW-1:0]) * PATH_AW'(MAX_ORBITALS)
                        + PATH_AW'(r_o[OW-1:0]);
    assign path_wr_addr = PATH_AW'(r_e[EW-1:0]) * PATH_AW'(MAX_ORBITALS)
                        + PATH_AW'(r_o[OW-1:0]);
    assign wgt_wr_addr  = WGT_AW'(r_e[OW-1:0]) * WGT_AW'(MAX_ORBITALS)
                        + WGT_AW'(r_o[OW-1:0]);

    assign path_val = ((r_e != i_n) ? r_path_rd : '0)
                    + ((r_o != last_col) ? r_right : '0)
                    + (((r_e == i_n) && (r_o == last_col)) ? DATA_W'(1) : '0);
    assign wgt_val  = (r_o == '0) ? '0 : r_acc + r_path_rd;

    always_comb begin
        n_state = r_state;
        n_e     = r_e;
        n_o     = r_o;
        n_right = r_right;
        n_acc   = r_acc;
        o_done  = 1'b0;
        path_we = 1'b0;
        wgt_we  = 1'b0;
        case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    if ((i_n == '0) || (i_n > i_l)) begin
                        o_done = 1'b1;
                    end else begin
                        n_e     = i_n;
                        n_o     = last_col;
                        n_state = T_PATH_RD;
                    end
                end
            end
            T_PATH_RD: begin
                n_state = T_PATH_WR;
            end
            T_PATH_WR: begin
                path_we = 1'b1;
                n_right = path_val;
                n_state = T_PATH_RD;
                if (r_o == '0) begin
                    if (r_e == '0) begin
                        n_o     = '0;
                        n_state = T_WGT_RD;
                    end else begin
                        n_e = r_e - CFG_W'(1);
                        n_o = last_col;
                    end
                end else begin
                    n_o = r_o - CFG_W'(1);
                end
            end
            T_WGT_RD: begin
                n_state = T_WGT_WR;
            end
            T_WGT_WR: begin
                wgt_we  = 1'b1;
                n_acc   = wgt_val;
                n_state = T_WGT_RD;
                if (r_o == last_col) begin
                    if (r_e == i_n - CFG_W'(1)) begin
                        o_done  = 1'b1;
                        n_state = T_IDLE;
                    end else begin
                        n_e = r_e + CFG_W'(1);
                        n_o = '0;
                    end
                end else begin
                    n_o = r_o + CFG_W'(1);
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_e     <= n_e;
        r_o     <= n_o;
        r_right <= n_right;
        r_acc   <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (path_we) begin
            path_mem[path_wr_addr] <= path_val;
        end
        if (path_rd_en) begin
            r_path_rd <= path_mem[path_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wgt_we) begin
            wgt_mem[wgt_wr_addr] <= wgt_val;
        end
        if (i_rd_en) begin
            r_wgt_rd <= wgt_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_wgt_rd;

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_state != T_IDLE)) |-> (r_state == T_WGT_WR))
        else $error("table build finished outside weight write");

    a_no_wr_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(path_we && wgt_we))
        else $error("path and weight writes in one cycle");

    a_wgt_follows_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_WGT_WR) |-> $past(r_state == T_WGT_RD))
        else $error("weight write without preceding read");

endmodule

>>> hw/rtl/crank_scan.sv
module crank_scan #(
    parameter int  MAX_ORBITALS = crank_pkg::MAX_ORBITALS_DEF,
    localparam int WGT_AW       = $clog2(MAX_ORBITALS * MAX_ORBITALS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [crank_pkg::DATA_W-1:0] i_occ,
    input  logic [crank_pkg::CFG_W-1:0]  i_n,
    input  logic [crank_pkg::CFG_W-1:0]  i_l,
    output logic                         o_rd_en,
    output logic [WGT_AW-1:0]            o_rd_addr,
    input  logic [crank_pkg::DATA_W-1:0] i_rd_data,
    output logic                         o_done,
    output crank_pkg::t_scan_res         o_res
);
    import crank_pkg::*;

    localparam int OW = $clog2(MAX_ORBITALS);

    typedef enum logic [3:0] {
        SC_IDLE  = 4'b0001,
        SC_RUN   = 4'b0010,
        SC_DRAIN = 4'b0100,
        SC_DONE  = 4'b1000
    } t_sstate;

    t_sstate           r_state, n_state;
    logic [DATA_W-1:0] r_occ;
    logic [POS_W-1:0]  r_p;
    logic [CFG_W-1:0]  r_k;
    logic [CFG_W-1:0]  r_cnt;
    logic              r_hi;
    logic [DATA_W-1:0] r_acc;
    logic              r_rd_v;

    logic              bit_set;
    logic              in_use;
    logic [CFG_W-1:0]  pos;
    logic [CFG_W-1:0]  col;
    logic              running;

    assign running = (r_state == SC_RUN);
    assign bit_set = r_occ[r_p];
    assign pos     = CFG_W'(r_p);
    assign in_use  = pos < i_l;
    assign col     = pos - r_k;
    assign o_rd_en = running && bit_set && in_use && (r_k < i_n)
                   && (r_k < CFG_W'(MAX_ORBITALS));
    assign o_rd_addr = WGT_AW'(r_k[OW-1:0]) * WGT_AW'(MAX_ORBITALS)
                     + WGT_AW'(col[OW-1:0]);

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    n_state = SC_RUN;
                end
            end
            SC_RUN: begin
                if (r_p == POS_W'(DATA_W - 1)) begin
                    n_state = SC_DRAIN;
                end
            end
            SC_DRAIN: begin
                n_state = SC_DONE;
            end
            SC_DONE: begin
                o_done  = 1'b1;
                n_state = SC_IDLE;
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= o_rd_en;
        end
        if ((r_state == SC_IDLE) && i_start) begin
            r_occ <= i_occ;
            r_p   <= '0;
            r_k   <= '0;
            r_cnt <= '0;
            r_hi  <= 1'b0;
            r_acc <= '0;
        end else begin
            if (running) begin
                r_p   <= r_p + POS_W'(1);
                r_cnt <= r_cnt + CFG_W'(bit_set);
                r_k   <= r_k + CFG_W'(bit_set && in_use);
                r_hi  <= r_hi || (bit_set && !in_use);
            end
            if (r_rd_v) begin
                r_acc <= r_acc + i_rd_data;
            end
        end
    end

    always_comb begin
        if (i_n > i_l) begin
            o_res.status = ST_SIZE;
        end else if (r_hi) begin
            o_res.status = ST_RANGE;
        end else if (r_cnt != i_n) begin
            o_res.status = ST_COUNT;
        end else begin
            o_res.status = ST_OK;
        end
        o_res.rank = (o_res.status == ST_OK) ? r_acc : '0;
    end

    a_rd_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> running)
        else $error("weight read outside scan");

    a_drain_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SC_DRAIN) |-> $past(r_state == SC_RUN))
        else $error("drain not preceded by scan");

    a_no_pending_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SC_DONE) |-> !r_rd_v)
        else $error("weight read still pending at completion");

endmodule

>>> hw/rtl/combination_rank_core.sv
// When tables are current, an accepted item goes straight to the scan; rank and status are registered.
// After a register write, the first item first rebuilds the tables: a read and a write state
//   per path entry ((N+1)*(L-N+1)), then per weight entry (N*(L-N+1)).
// A new item is taken only when idle, after the last result is loaded; the 32-position scan uses one weight read port.
// Reset: synchronous active low; N=1, L=2, tables marked stale, table contents undefined.
module combination_rank_core #(
    parameter int MAX_ORBITALS = crank_pkg::MAX_ORBITALS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crank_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [crank_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [crank_pkg::DATA_W-1:0]    i_occupation,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [crank_pkg::DATA_W-1:0]    o_rank,
    output logic [crank_pkg::STATUS_W-1:0]  o_status
);
    import crank_pkg::*;

    localparam int WGT_AW = $clog2(MAX_ORBITALS * MAX_ORBITALS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BUILD = 4'b0010,
        S_SCAN  = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_num_pairs;
    logic [CFG_W-1:0]    r_num_orbitals;
    logic                r_tables_ready;
    logic                r_build_start, n_build_start;
    logic                r_scan_start, n_scan_start;
    logic [DATA_W-1:0]   r_occ;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_rank;
    logic [STATUS_W-1:0] r_status;

    logic                accept;
    logic                cfg_hit;
    logic                out_free;
    logic                load_out;
    logic [CFG_W-1:0]    eff_l;
    logic                tbl_done;
    logic                scan_done;
    logic                rd_en;
    logic [WGT_AW-1:0]   rd_addr;
    logic [DATA_W-1:0]   rd_data;
    t_scan_res           scan_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign cfg_hit    = i_cfg_we
                      && ((i_cfg_idx == CFG_NUM_PAIRS) || (i_cfg_idx == CFG_NUM_ORBITALS));
    assign out_free   = !r_out_valid || i_out_ready;
    assign eff_l      = (r_num_orbitals > CFG_W'(MAX_ORBITALS))
                      ? CFG_W'(MAX_ORBITALS) : r_num_orbitals;

    crank_table #(
        .MAX_ORBITALS (MAX_ORBITALS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_build_start),
        .i_n       (r_num_pairs),
        .i_l       (eff_l),
        .o_done    (tbl_done),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    crank_scan #(
        .MAX_ORBITALS (MAX_ORBITALS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_scan_start),
        .i_occ     (r_occ),
        .i_n       (r_num_pairs),
        .i_l       (eff_l),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_done    (scan_done),
        .o_res     (scan_res)
    );

    always_comb begin
        n_state       = r_state;
        n_build_start = 1'b0;
        n_scan_start  = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_tables_ready) begin
                        n_scan_start = 1'b1;
                        n_state      = S_SCAN;
                    end else begin
                        n_build_start = 1'b1;
                        n_state       = S_BUILD;
                    end
                end
            end
            S_BUILD: begin
                if (tbl_done) begin
                    n_scan_start = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_num_pairs    <= NUM_PAIRS_RST;
            r_num_orbitals <= NUM_ORBITALS_RST;
            r_tables_ready <= 1'b0;
            r_build_start  <= 1'b0;
            r_scan_start   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_build_start <= n_build_start;
            r_scan_start  <= n_scan_start;
            if (i_cfg_we && (i_cfg_idx == CFG_NUM_PAIRS)) begin
                r_num_pairs <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_NUM_ORBITALS)) begin
                r_num_orbitals <= i_cfg_data;
            end
            if (cfg_hit) begin
                r_tables_ready <= 1'b0;
            end else if (tbl_done) begin
                r_tables_ready <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_occ <= i_occupation;
        end
        if (load_out) begin
            r_rank   <= scan_res.rank;
            r_status <= scan_res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rank      = r_rank;
    assign o_status    = r_status;

    a_build_done_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_done |-> (r_state == S_BUILD))
        else $error("table build finished outside build state");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (r_state == S_SCAN))
        else $error("scan finished outside scan state");

    a_cfg_stales_tables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> !r_tables_ready)
        else $error("tables still marked current after register write");

    a_rank_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_rank == '0))
        else $error("nonzero rank with error status");

endmodule
